// ===== rtl/core/decimal_number_parser_macros.svh =====
// assertion macros used by the checker of the decimal number parser
`ifndef DECIMAL_NUMBER_PARSER_MACROS_SVH
`define DECIMAL_NUMBER_PARSER_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define DNP_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define DNP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/dnp_pkg.sv =====
// types, character codes and constants of the decimal number parser
package dnp_pkg;

    localparam int VALUE_W = 48;
    localparam int EXP_W   = 9;
    localparam int CNT_W   = 8;

    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_POINT = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam logic [CNT_W-1:0]        CNT_MAX = 8'hFF;
    localparam logic signed [EXP_W-1:0] EXP_MAX = 9'sd255;
    localparam logic [VALUE_W-2:0]      MAG_MAX = '1;

    localparam logic OP_MUL10_ADD = 1'b0;
    localparam logic OP_SUB       = 1'b1;

    typedef struct packed {
        logic [7:0] character;
        logic       restart;
    } t_in_item;

    typedef struct packed {
        logic                      found;
        logic signed [VALUE_W-1:0] number_value;
        logic [7:0]                chars_used;
    } t_out_item;

    function automatic logic [31:0] pow10(input logic [3:0] k);
        logic [31:0] p;
        case (k)
            4'd0:    p = 32'd1;
            4'd1:    p = 32'd10;
            4'd2:    p = 32'd100;
            4'd3:    p = 32'd1000;
            4'd4:    p = 32'd10000;
            4'd5:    p = 32'd100000;
            4'd6:    p = 32'd1000000;
            4'd7:    p = 32'd10000000;
            4'd8:    p = 32'd100000000;
            4'd9:    p = 32'd1000000000;
            default: p = 32'd0;
        endcase
        return p;
    endfunction

endpackage

// ===== rtl/core/dnp_step_unit.sv =====
// shared shift-add / subtract unit: a*10+b or a-b with borrow in the top bit
module dnp_step_unit
    import dnp_pkg::*;
#(
    parameter int W = 52
) (
    input  logic         i_op,
    input  logic [W-1:0] i_a,
    input  logic [W-1:0] i_b,
    output logic [W:0]   o_y
);

    logic [W:0] a_ext;
    logic [W:0] b_ext;

    assign a_ext = {1'b0, i_a};
    assign b_ext = {1'b0, i_b};

    always_comb begin
        if (i_op == OP_SUB) begin
            o_y = a_ext - b_ext;
        end else begin
            o_y = (a_ext << 3) + (a_ext << 1) + b_ext;
        end
    end

endmodule

// ===== rtl/core/decimal_number_parser.sv =====
// Streaming ASCII decimal parser: optional sign, digits with at most one point, first
// MAX_DIGITS digits kept, result in signed fixed point with FRAC_BITS fraction bits,
// truncated toward zero and saturated at 2^47-1 in magnitude. Sign, digit and point
// characters are taken one per clock while idle. A terminator (any other character,
// or a second point) is consumed by the handshake but not counted in chars_used; it
// starts the scaling, during which the input is not ready. Scaling runs on one shared
// shift-add / subtract unit: a number with kept fraction digits takes a restoring
// division of MANTISSA_BITS+FRAC_BITS steps, any other number takes one
// multiply-by-ten per exponent step then a closing check, stopping early on
// saturation; either path has a setup state and a result-loading state. Characters
// are accepted again while the result waits to be taken.
module decimal_number_parser
    import dnp_pkg::*;
#(
    parameter int MAX_DIGITS = 8,
    parameter int FRAC_BITS  = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_data
);

    localparam int MANT_W = $clog2(10**MAX_DIGITS);
    localparam int DIV_W  = MANT_W + 1;
    localparam int NUM_W  = MANT_W + FRAC_BITS;
    localparam int ACC_W  = ((NUM_W > VALUE_W) ? NUM_W : VALUE_W) + 4;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_INIT = 3'd1;
    localparam logic [2:0] S_MUL  = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    logic [2:0]              r_state, n_state;
    logic [MANT_W-1:0]       r_mant, n_mant;
    logic signed [EXP_W-1:0] r_exp, n_exp;
    logic [CNT_W-1:0]        r_dcnt, n_dcnt;
    logic                    r_seen, n_seen;
    logic                    r_neg, n_neg;
    logic                    r_first, n_first;
    logic [CNT_W-1:0]        r_pos, n_pos;
    logic [ACC_W-1:0]        r_acc, n_acc;
    logic [MANT_W-1:0]       r_rem, n_rem;
    logic [DIV_W-1:0]        r_div, n_div;
    logic [CNT_W-1:0]        r_cnt, n_cnt;
    logic                    r_out_valid, n_out_valid;
    t_out_item               r_out, n_out;

    logic [MANT_W-1:0]       e_mant;
    logic signed [EXP_W-1:0] e_exp;
    logic [CNT_W-1:0]        e_dcnt;
    logic                    e_seen;
    logic                    e_neg;
    logic                    e_first;
    logic [CNT_W-1:0]        e_pos;
    logic [CNT_W-1:0]        dcnt_inc;
    logic [CNT_W-1:0]        pos_inc;
    logic [7:0]              ch;
    logic                    accept;
    logic                    is_sign;
    logic                    is_digit;
    logic                    is_point;
    logic [DIV_W-1:0]        shifted;
    logic                    borrow;
    logic                    over;
    logic [VALUE_W-2:0]      mag;
    logic [VALUE_W-1:0]      mag_ext;
    logic                    unit_op;
    logic [ACC_W-1:0]        unit_a;
    logic [ACC_W-1:0]        unit_b;
    logic [ACC_W:0]          unit_y;

    dnp_step_unit #(
        .W (ACC_W)
    ) u_step (
        .i_op (unit_op),
        .i_a  (unit_a),
        .i_b  (unit_b),
        .o_y  (unit_y)
    );

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign ch     = i_in_data.character;
    assign accept = i_in_valid && o_in_ready;

    // restart drops the partial parse before this character is looked at
    assign e_mant  = i_in_data.restart ? '0 : r_mant;
    assign e_exp   = i_in_data.restart ? '0 : r_exp;
    assign e_dcnt  = i_in_data.restart ? '0 : r_dcnt;
    assign e_seen  = i_in_data.restart ? 1'b0 : r_seen;
    assign e_neg   = i_in_data.restart ? 1'b0 : r_neg;
    assign e_first = i_in_data.restart ? 1'b1 : r_first;
    assign e_pos   = i_in_data.restart ? '0 : r_pos;

    assign dcnt_inc = (e_dcnt != CNT_MAX) ? e_dcnt + 8'd1 : e_dcnt;
    assign pos_inc  = (e_pos != CNT_MAX) ? e_pos + 8'd1 : e_pos;

    assign is_sign  = e_first && ((ch == CH_MINUS) || (ch == CH_PLUS));
    assign is_digit = ch inside {[CH_ZERO:CH_NINE]};
    assign is_point = (ch == CH_POINT) && !e_seen;

    assign shifted = {r_rem, r_acc[NUM_W-1]};
    assign borrow  = unit_y[ACC_W];
    assign over    = |r_acc[ACC_W-1:VALUE_W-1];
    assign mag     = over ? MAG_MAX : r_acc[VALUE_W-2:0];
    assign mag_ext = {1'b0, mag};

    always_comb begin
        case (r_state)
            S_MUL: begin
                unit_op = OP_MUL10_ADD;
                unit_a  = r_acc;
                unit_b  = '0;
            end
            S_DIV: begin
                unit_op = OP_SUB;
                unit_a  = ACC_W'(shifted);
                unit_b  = ACC_W'(r_div);
            end
            default: begin
                unit_op = OP_MUL10_ADD;
                unit_a  = ACC_W'(e_mant);
                unit_b  = ACC_W'(4'(ch - CH_ZERO));
            end
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_mant      = r_mant;
        n_exp       = r_exp;
        n_dcnt      = r_dcnt;
        n_seen      = r_seen;
        n_neg       = r_neg;
        n_first     = r_first;
        n_pos       = r_pos;
        n_acc       = r_acc;
        n_rem       = r_rem;
        n_div       = r_div;
        n_cnt       = r_cnt;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_out_ready;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_mant  = e_mant;
                    n_exp   = e_exp;
                    n_dcnt  = e_dcnt;
                    n_seen  = e_seen;
                    n_neg   = e_neg;
                    n_first = 1'b0;
                    n_pos   = e_pos;
                    if (is_sign) begin
                        n_neg = (ch == CH_MINUS);
                        n_pos = pos_inc;
                    end else if (is_digit) begin
                        n_dcnt = dcnt_inc;
                        n_pos  = pos_inc;
                        if (dcnt_inc <= CNT_W'(MAX_DIGITS)) begin
                            n_mant = unit_y[MANT_W-1:0];
                            if (e_seen) begin
                                n_exp = e_exp - 9'sd1;
                            end
                        end else if (!e_seen && (e_exp < EXP_MAX)) begin
                            n_exp = e_exp + 9'sd1;
                        end
                    end else if (is_point) begin
                        n_seen = 1'b1;
                        n_pos  = pos_inc;
                    end else begin
                        n_first = e_first;
                        n_acc   = ACC_W'(e_mant) << FRAC_BITS;
                        n_state = S_INIT;
                    end
                end
            end
            S_INIT: begin
                n_rem = '0;
                if (r_exp[EXP_W-1]) begin
                    n_div   = DIV_W'(pow10(4'(-r_exp)));
                    n_cnt   = CNT_W'(NUM_W);
                    n_state = S_DIV;
                end else begin
                    n_cnt   = r_exp[CNT_W-1:0];
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                if ((r_cnt == '0) || over) begin
                    n_state = S_DONE;
                end else begin
                    n_acc = unit_y[ACC_W-1:0];
                    n_cnt = r_cnt - 8'd1;
                end
            end
            S_DIV: begin
                n_rem = borrow ? shifted[MANT_W-1:0] : unit_y[MANT_W-1:0];
                n_acc = ACC_W'({r_acc[NUM_W-2:0], !borrow});
                n_cnt = r_cnt - 8'd1;
                if (r_cnt == 8'd1) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid        = 1'b1;
                    n_out.found        = (r_dcnt != '0);
                    n_out.number_value = '0;
                    n_out.chars_used   = '0;
                    if (r_dcnt != '0) begin
                        n_out.number_value = r_neg ? -mag_ext : mag_ext;
                        n_out.chars_used   = r_pos;
                    end
                    n_mant  = '0;
                    n_exp   = '0;
                    n_dcnt  = '0;
                    n_seen  = 1'b0;
                    n_neg   = 1'b0;
                    n_first = 1'b1;
                    n_pos   = '0;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_mant      <= '0;
            r_exp       <= '0;
            r_dcnt      <= '0;
            r_seen      <= 1'b0;
            r_neg       <= 1'b0;
            r_first     <= 1'b1;
            r_pos       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_mant      <= n_mant;
            r_exp       <= n_exp;
            r_dcnt      <= n_dcnt;
            r_seen      <= n_seen;
            r_neg       <= n_neg;
            r_first     <= n_first;
            r_pos       <= n_pos;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
        r_rem <= n_rem;
        r_div <= n_div;
        r_cnt <= n_cnt;
        r_out <= n_out;
    end

endmodule

// ===== rtl/core/dnp_checker.sv =====
// port-level checker of the decimal number parser and its bind
`include "decimal_number_parser_macros.svh"

module dnp_checker
    import dnp_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_ready,
    input t_in_item  i_in_data,
    input logic      o_out_valid,
    input logic      i_out_ready,
    input t_out_item o_out_data
);

    `DNP_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready,
        o_out_valid && $stable(o_out_data), "result changed while stalled")

    `DNP_ASSERT_SAME(a_not_found_zero, i_clk, i_rst_n, o_out_valid && !o_out_data.found,
        (o_out_data.number_value == '0) && (o_out_data.chars_used == '0),
        "empty transaction carries a value or length")

    `DNP_ASSERT_SAME(a_found_len, i_clk, i_rst_n, o_out_valid && o_out_data.found,
        (o_out_data.chars_used != '0) && (o_out_data.number_value != 48'sh8000_0000_0000),
        "found number with no length or out of range")

    // a character outside digits, point and signs always ends the number
    `DNP_ASSERT_NEXT(a_term_busy, i_clk, i_rst_n,
        i_in_valid && o_in_ready
        && ((i_in_data.character < CH_ZERO) || (i_in_data.character > CH_NINE))
        && (i_in_data.character != CH_POINT) && (i_in_data.character != CH_PLUS)
        && (i_in_data.character != CH_MINUS),
        !o_in_ready, "terminator did not start scaling")

endmodule

bind decimal_number_parser dnp_checker u_dnp_checker (.*);

// ===== sim/tb.sv =====
// testbench of the decimal number parser: directed table then random character streams
module tb;
    import dnp_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_DIGITS = 8;
    localparam int FRAC_BITS  = 16;
    localparam int N_RANDOM   = 1950;
    localparam int IDLE_LIMIT = 5000;
    localparam int HOLD_AT    = 40;
    localparam int HOLD_LEN   = 400;
    localparam int DRAIN_WAIT = 300;
    localparam logic [63:0] MAG_LIMIT = {17'd0, MAG_MAX};

    typedef struct packed {
        t_in_item  item;
        logic      known;
        t_out_item want;
    } t_row;

    logic      i_clk;
    logic      i_rst_n   = 1'b0;
    logic      in_valid  = 1'b0;
    t_in_item  in_data   = '0;
    logic      out_ready = 1'b0;
    logic      o_in_ready;
    logic      o_out_valid;
    t_out_item o_out_data;

    t_row      stim[$];
    t_row      dir_table [0:23];
    t_out_item expected_numbers[$];
    int        n_fail      = 0;
    int        n_results   = 0;
    int        idle_cycles = 0;

    // predictor state
    logic [63:0] st_mant;
    int          st_exp;
    int          st_digits;
    bit          st_point;
    bit          st_neg;
    bit          st_first;
    int          st_pos;

    decimal_number_parser #(
        .MAX_DIGITS(MAX_DIGITS),
        .FRAC_BITS (FRAC_BITS)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(out_ready),
        .o_out_data (o_out_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic void parse_clear();
        st_mant   = '0;
        st_exp    = 0;
        st_digits = 0;
        st_point  = 1'b0;
        st_neg    = 1'b0;
        st_first  = 1'b1;
        st_pos    = 0;
    endfunction

    function automatic void pos_step();
        if (st_pos < 255) st_pos++;
    endfunction

    function automatic logic [63:0] scaled_mag();
        logic [63:0] mag;
        logic [63:0] div;
        int          e;
        e = st_exp;
        if (st_mant == 0) return '0;
        mag = st_mant << FRAC_BITS;
        if (e < 0) begin
            div = 64'd1;
            while (e < 0) begin
                div = div * 10;
                e++;
            end
            mag = mag / div;
        end else begin
            while (e > 0 && mag <= MAG_LIMIT) begin
                mag = mag * 10;
                e--;
            end
        end
        if (mag > MAG_LIMIT) mag = MAG_LIMIT;
        return mag;
    endfunction

    // returns 1 when this character ends a number
    function automatic bit parse_char(input t_in_item it, output t_out_item res);
        logic [63:0] mag;
        logic [7:0]  ch;
        ch  = it.character;
        res = '0;
        if (it.restart) parse_clear();
        if (st_first) begin
            st_first = 1'b0;
            if (ch == CH_MINUS) begin
                st_neg = 1'b1;
                pos_step();
                return 1'b0;
            end
            if (ch == CH_PLUS) begin
                pos_step();
                return 1'b0;
            end
        end
        if (ch >= CH_ZERO && ch <= CH_NINE) begin
            if (st_digits < 255) st_digits++;
            if (st_digits <= MAX_DIGITS) begin
                if (st_point) st_exp--;
                st_mant = st_mant * 10 + 64'(ch - CH_ZERO);
            end else if (!st_point && st_exp < int'(EXP_MAX)) begin
                st_exp++;
            end
            pos_step();
            return 1'b0;
        end
        if (ch == CH_POINT && !st_point) begin
            st_point = 1'b1;
            pos_step();
            return 1'b0;
        end
        if (st_digits != 0) begin
            mag              = scaled_mag();
            res.found        = 1'b1;
            res.number_value = st_neg ? 48'(64'd0 - mag) : 48'(mag);
            res.chars_used   = 8'(st_pos);
        end
        parse_clear();
        return 1'b1;
    endfunction

    task automatic add(input logic [7:0] ch, input logic rs);
        t_row r;
        r.item.character = ch;
        r.item.restart   = rs;
        r.known          = 1'b0;
        r.want           = '0;
        stim.push_back(r);
    endtask

    // kind 0: all zeros, 1: all nines, else random digits
    task automatic add_digits(input int n, input int kind);
        logic [7:0] d;
        for (int k = 0; k < n; k++) begin
            d = kind == 0 ? CH_ZERO : kind == 1 ? CH_NINE : CH_ZERO + 8'($urandom_range(0, 9));
            add(d, $urandom_range(0, 99) < 2);
        end
    endtask

    task automatic add_number(input bit go_long);
        int         r;
        int         n_int;
        int         kind;
        int         first;
        logic [7:0] ch;
        first = stim.size();
        if (!go_long && $urandom_range(0, 99) < 8) begin
            repeat ($urandom_range(1, 4)) add(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
            return;
        end
        case ($urandom_range(0, 2))
            1: add(CH_MINUS, 1'b0);
            2: add(CH_PLUS, 1'b0);
            default: ;
        endcase
        r     = $urandom_range(0, 99);
        n_int = (go_long || r < 1) ? $urandom_range(260, 300) :
                r < 30 ? $urandom_range(9, 20) : $urandom_range(0, 8);
        kind  = $urandom_range(0, 9);
        add_digits(n_int, kind);
        if ($urandom_range(0, 1)) begin
            add(CH_POINT, 1'b0);
            add_digits($urandom_range(0, 10), kind);
        end
        case ($urandom_range(0, 3))
            0: add(CH_POINT, 1'b0);
            1: add($urandom_range(0, 1) ? CH_MINUS : CH_PLUS, 1'b0);
            default: begin
                do ch = 8'($urandom_range(0, 255));
                while ((ch >= CH_ZERO && ch <= CH_NINE) || ch == CH_POINT);
                add(ch, $urandom_range(0, 3) == 0);
            end
        endcase
        if (stim.size() > first && $urandom_range(0, 9) == 0) stim[first].item.restart = 1'b1;
    endtask

    task automatic take_number(input t_out_item got);
        t_out_item want;
        n_results++;
        if (expected_numbers.size() == 0) begin
            if (n_fail < 10)
                $display("unexpected result: found=%0b value=%0d used=%0d",
                         got.found, got.number_value, got.chars_used);
            n_fail++;
            return;
        end
        want = expected_numbers.pop_front();
        if (got !== want) begin
            if (n_fail < 10)
                $display("result %0d: expected found=%0b value=%0d used=%0d, got found=%0b value=%0d used=%0d",
                         n_results, want.found, want.number_value, want.chars_used,
                         got.found, got.number_value, got.chars_used);
            n_fail++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_valid && o_in_ready) || (o_out_valid && out_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == IDLE_LIMIT) begin
            $display("tb NOT OK");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // receiver
    initial begin
        int gap;
        bit burst;
        bit held;
        burst = 1'b0;
        held  = 1'b0;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if ($urandom_range(0, 39) == 0) burst = ~burst;
            gap = burst ? 0 : $urandom_range(0, 19);
            if (n_results == HOLD_AT && !held) begin
                held = 1'b1;
                gap  = HOLD_LEN;
            end
            if (gap > 0) begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
            take_number(o_out_data);
        end
    end

    // sender
    initial begin
        t_row      row;
        t_out_item pred;
        int        gap;
        bit        burst;
        dir_table = '{
            '{'{CH_PLUS,  1'b0}, 1'b0, '0},
            '{'{"x",      1'b0}, 1'b1, '{1'b0, 48'sd0, 8'd0}},
            '{'{CH_MINUS, 1'b0}, 1'b0, '0},
            '{'{CH_POINT, 1'b0}, 1'b0, '0},
            '{'{8'hFF,    1'b0}, 1'b1, '{1'b0, 48'sd0, 8'd0}},
            '{'{CH_MINUS, 1'b0}, 1'b0, '0},
            '{'{CH_ZERO,  1'b0}, 1'b0, '0},
            '{'{8'h00,    1'b0}, 1'b1, '{1'b1, 48'sd0, 8'd2}},
            '{'{CH_NINE,  1'b0}, 1'b0, '0},
            '{'{CH_POINT, 1'b0}, 1'b0, '0},
            '{'{"5",      1'b0}, 1'b0, '0},
            '{'{CH_POINT, 1'b0}, 1'b0, '0},
            '{'{"7",      1'b0}, 1'b0, '0},
            '{'{"a",      1'b1}, 1'b1, '{1'b0, 48'sd0, 8'd0}},
            '{'{"3",      1'b1}, 1'b0, '0},
            '{'{CH_PLUS,  1'b0}, 1'b0, '0},
            '{'{CH_POINT, 1'b0}, 1'b0, '0},
            '{'{CH_POINT, 1'b0}, 1'b1, '{1'b0, 48'sd0, 8'd0}},
            '{'{CH_ZERO,  1'b0}, 1'b0, '0},
            '{'{CH_POINT, 1'b0}, 1'b0, '0},
            '{'{CH_ZERO,  1'b0}, 1'b0, '0},
            '{'{CH_ZERO,  1'b0}, 1'b0, '0},
            '{'{"1",      1'b0}, 1'b0, '0},
            '{'{CH_MINUS, 1'b0}, 1'b0, '0}
        };
        foreach (dir_table[k]) stim.push_back(dir_table[k]);
        add_number(1'b1);
        while (stim.size() < $size(dir_table) + N_RANDOM) add_number(1'b0);
        parse_clear();
        burst = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (stim.size() != 0) begin
            row = stim.pop_front();
            if ($urandom_range(0, 39) == 0) burst = ~burst;
            gap = burst ? 0 : $urandom_range(0, 19);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            in_valid <= 1'b1;
            in_data  <= row.item;
            do @(posedge i_clk); while (!o_in_ready);
            if (parse_char(row.item, pred))
                expected_numbers.push_back(row.known ? row.want : pred);
        end
        in_valid <= 1'b0;
        while (expected_numbers.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (n_fail == 0 && expected_numbers.size() == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/dnp_pkg.sv
rtl/core/dnp_step_unit.sv
rtl/core/decimal_number_parser.sv
rtl/core/dnp_checker.sv
sim/tb.sv
